/* rtl/ceu8_pkg.sv */
// ----------------------------------------------------------------------------
// ceu8_pkg
// Types, operation codes and status bit constants of the 8-bit execute unit.
// ----------------------------------------------------------------------------
package ceu8_pkg;

    typedef logic [6:0] kind_t;
    typedef logic [7:0] byte_t;

    // Status bit positions: N V 1 B D I Z C
    localparam int FB_C = 0;
    localparam int FB_Z = 1;
    localparam int FB_I = 2;
    localparam int FB_D = 3;
    localparam int FB_V = 6;
    localparam int FB_N = 7;

    localparam byte_t PUSH_STATUS_SET = 8'b0011_0000;
    localparam byte_t PULL_STATUS_MASK = 8'b1110_1111;
    localparam byte_t PULL_STATUS_SET = 8'b0010_0000;

    localparam kind_t K_LDA = 7'd0;
    localparam kind_t K_LDX = 7'd1;
    localparam kind_t K_LDY = 7'd2;
    localparam kind_t K_EOR = 7'd3;
    localparam kind_t K_AND = 7'd4;
    localparam kind_t K_ORA = 7'd5;
    localparam kind_t K_ADC = 7'd6;
    localparam kind_t K_SBC = 7'd7;
    localparam kind_t K_CMP = 7'd8;
    localparam kind_t K_CPX = 7'd9;
    localparam kind_t K_CPY = 7'd10;
    localparam kind_t K_BIT = 7'd11;
    localparam kind_t K_NOP = 7'd12;
    localparam kind_t K_ANC = 7'd13;
    localparam kind_t K_ALR = 7'd14;
    localparam kind_t K_LAX = 7'd15;
    localparam kind_t K_ATX = 7'd16;
    localparam kind_t K_ASL_M = 7'd17;
    localparam kind_t K_LSR_M = 7'd18;
    localparam kind_t K_ROL_M = 7'd19;
    localparam kind_t K_ROR_M = 7'd20;
    localparam kind_t K_ASL_A = 7'd21;
    localparam kind_t K_LSR_A = 7'd22;
    localparam kind_t K_ROL_A = 7'd23;
    localparam kind_t K_ROR_A = 7'd24;
    localparam kind_t K_INC = 7'd25;
    localparam kind_t K_DEC = 7'd26;
    localparam kind_t K_SLO = 7'd27;
    localparam kind_t K_SRE = 7'd28;
    localparam kind_t K_RLA = 7'd29;
    localparam kind_t K_RRA = 7'd30;
    localparam kind_t K_ISC = 7'd31;
    localparam kind_t K_DCP = 7'd32;
    localparam kind_t K_CLC = 7'd33;
    localparam kind_t K_CLD = 7'd34;
    localparam kind_t K_CLI = 7'd35;
    localparam kind_t K_CLV = 7'd36;
    localparam kind_t K_DEX = 7'd37;
    localparam kind_t K_DEY = 7'd38;
    localparam kind_t K_INX = 7'd39;
    localparam kind_t K_INY = 7'd40;
    localparam kind_t K_SEC = 7'd41;
    localparam kind_t K_SED = 7'd42;
    localparam kind_t K_SEI = 7'd43;
    localparam kind_t K_TAX = 7'd44;
    localparam kind_t K_TAY = 7'd45;
    localparam kind_t K_TSX = 7'd46;
    localparam kind_t K_TXA = 7'd47;
    localparam kind_t K_TXS = 7'd48;
    localparam kind_t K_TYA = 7'd49;
    localparam kind_t K_STA = 7'd50;
    localparam kind_t K_STX = 7'd51;
    localparam kind_t K_STY = 7'd52;
    localparam kind_t K_SAX = 7'd53;
    localparam kind_t K_PHA = 7'd54;
    localparam kind_t K_PHP = 7'd55;
    localparam kind_t K_PLA = 7'd56;
    localparam kind_t K_PLP = 7'd57;
    localparam kind_t K_BCC = 7'd58;
    localparam kind_t K_BCS = 7'd59;
    localparam kind_t K_BVC = 7'd60;
    localparam kind_t K_BVS = 7'd61;
    localparam kind_t K_BNE = 7'd62;
    localparam kind_t K_BEQ = 7'd63;
    localparam kind_t K_BPL = 7'd64;
    localparam kind_t K_BMI = 7'd65;

    // Update N and Z of a status byte from a result byte.
    function automatic byte_t with_nz(input byte_t flags, input byte_t v);
        byte_t t;
        t = flags;
        t[FB_N] = v[7];
        t[FB_Z] = (v == 8'h00);
        return t;
    endfunction

endpackage

/* rtl/ceu8_cmd_if.sv */
// ----------------------------------------------------------------------------
// ceu8_cmd_if
// Operation channel: kind and operand byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ceu8_cmd_if;
    logic                 valid;
    logic                 ready;
    ceu8_pkg::kind_t      kind;
    ceu8_pkg::byte_t      operand;

    modport source (output valid, output kind, output operand, input ready);
    modport sink   (input valid, input kind, input operand, output ready);
endinterface

/* rtl/ceu8_res_if.sv */
// ----------------------------------------------------------------------------
// ceu8_res_if
// Result channel: memory write byte, branch flag and register file image.
// ----------------------------------------------------------------------------
interface ceu8_res_if;
    logic                 valid;
    logic                 ready;
    ceu8_pkg::byte_t      value_out;
    logic                 mem_write;
    logic                 branch_taken;
    ceu8_pkg::byte_t      acc_out;
    ceu8_pkg::byte_t      x_out;
    ceu8_pkg::byte_t      y_out;
    ceu8_pkg::byte_t      sp_out;
    ceu8_pkg::byte_t      flags_out;

    modport source (
        output valid, output value_out, output mem_write, output branch_taken,
        output acc_out, output x_out, output y_out, output sp_out, output flags_out,
        input ready
    );
    modport sink (
        input valid, input value_out, input mem_write, input branch_taken,
        input acc_out, input x_out, input y_out, input sp_out, input flags_out,
        output ready
    );
endinterface

/* rtl/cpu_execute_unit_8bit_unit.sv */
// ----------------------------------------------------------------------------
// cpu_execute_unit_8bit_unit
// Register file and ALU of an 8-bit 6502-style core.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation (kind, operand byte) per transfer. res returns
//   one result per operation: the byte to write with its write flag, the
//   branch condition and A, X, Y, SP and status after the operation.
//   An operation is captured in an input register at its transfer; when it
//   advances, the ALU result is written into the result register together
//   with the architectural registers, and res.valid rises from the result
//   register. One operation per cycle is sustained while the receiver does
//   not stall: the register feedback is a single ALU pass, so back-to-back
//   operations see the state left by the previous one.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more operation; cmd.ready drops only while
//   both stages are full.
//   Reset clears A, X, Y, SP and status to zero and empties both stages.
//   Unused kinds behave as NOP.
// ----------------------------------------------------------------------------
module cpu_execute_unit_8bit_unit (
    input  logic       clk,
    input  logic       rst_n,
    ceu8_cmd_if.sink   cmd,
    ceu8_res_if.source res
);
    import ceu8_pkg::*;

    // Input stage
    logic  cmd_valid_reg;
    kind_t cmd_kind_reg;
    byte_t cmd_operand_reg;

    // Architectural registers
    byte_t acc_reg, x_reg, y_reg, sp_reg, flag_reg;
    byte_t acc_next, x_next, y_next, sp_next, flag_next;

    // Result stage
    logic  res_valid_reg;
    byte_t res_value_reg;
    logic  res_write_reg;
    logic  res_branch_reg;
    byte_t res_acc_reg, res_x_reg, res_y_reg, res_sp_reg, res_flag_reg;

    byte_t wv_next;
    logic  wr_next;
    logic  br_next;

    logic  advance;

    // Shared ALU pieces
    byte_t     sh_in, asl_r, lsr_r, rol_r, ror_r;
    byte_t     inc_r, dec_r;
    byte_t     adc_in;
    logic      adc_cin;
    logic [8:0] sum9;
    logic      adc_v;
    byte_t     cmp_a, cmp_b;
    logic [8:0] diff9;

    assign advance   = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || advance;

    always_comb
    begin
        case (cmd_kind_reg)
            K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A: sh_in = acc_reg;
            K_ALR:                              sh_in = acc_reg & cmd_operand_reg;
            default:                            sh_in = cmd_operand_reg;
        endcase
    end

    assign asl_r = {sh_in[6:0], 1'b0};
    assign lsr_r = {1'b0, sh_in[7:1]};
    assign rol_r = {sh_in[6:0], flag_reg[FB_C]};
    assign ror_r = {flag_reg[FB_C], sh_in[7:1]};
    assign inc_r = cmd_operand_reg + 8'd1;
    assign dec_r = cmd_operand_reg - 8'd1;

    always_comb
    begin
        adc_cin = flag_reg[FB_C];
        case (cmd_kind_reg)
            K_SBC:   adc_in = ~cmd_operand_reg;
            K_RRA:
            begin
                adc_in  = ror_r;
                // the rotate has already replaced the carry
                adc_cin = cmd_operand_reg[0];
            end
            K_ISC:   adc_in = ~inc_r;
            default: adc_in = cmd_operand_reg;
        endcase
    end

    assign sum9  = {1'b0, acc_reg} + {1'b0, adc_in} + {8'd0, adc_cin};
    assign adc_v = (acc_reg[7] ^ sum9[7]) & (adc_in[7] ^ sum9[7]);

    always_comb
    begin
        case (cmd_kind_reg)
            K_CPX:   cmp_a = x_reg;
            K_CPY:   cmp_a = y_reg;
            default: cmp_a = acc_reg;
        endcase
        cmp_b = (cmd_kind_reg == K_DCP) ? dec_r : cmd_operand_reg;
    end

    assign diff9 = {1'b0, cmp_a} - {1'b0, cmp_b};

    always_comb
    begin : alu
        byte_t d;
        byte_t r;
        byte_t t;
        d         = cmd_operand_reg;
        r         = 8'h00;
        t         = flag_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        sp_next   = sp_reg;
        flag_next = flag_reg;
        wv_next   = 8'h00;
        wr_next   = 1'b0;
        br_next   = 1'b0;
        case (cmd_kind_reg)
            K_LDA:
            begin
                acc_next  = d;
                flag_next = with_nz(flag_reg, d);
            end
            K_LDX:
            begin
                x_next    = d;
                flag_next = with_nz(flag_reg, d);
            end
            K_LDY:
            begin
                y_next    = d;
                flag_next = with_nz(flag_reg, d);
            end
            K_EOR:
            begin
                acc_next  = acc_reg ^ d;
                flag_next = with_nz(flag_reg, acc_reg ^ d);
            end
            K_AND:
            begin
                acc_next  = acc_reg & d;
                flag_next = with_nz(flag_reg, acc_reg & d);
            end
            K_ORA:
            begin
                acc_next  = acc_reg | d;
                flag_next = with_nz(flag_reg, acc_reg | d);
            end
            K_ADC, K_SBC:
            begin
                t[FB_V]   = adc_v;
                t[FB_C]   = sum9[8];
                acc_next  = sum9[7:0];
                flag_next = with_nz(t, sum9[7:0]);
            end
            K_CMP, K_CPX, K_CPY:
            begin
                t[FB_C]   = ~diff9[8];
                flag_next = with_nz(t, diff9[7:0]);
            end
            K_BIT:
            begin
                t[FB_N]   = d[7];
                t[FB_V]   = d[6];
                t[FB_Z]   = ((d & acc_reg) == 8'h00);
                flag_next = t;
            end
            K_NOP:
            begin
                flag_next = flag_reg;
            end
            K_ANC:
            begin
                r         = acc_reg & d;
                t         = with_nz(flag_reg, r);
                t[FB_C]   = r[7];
                acc_next  = r;
                flag_next = t;
            end
            K_ALR:
            begin
                t[FB_C]   = sh_in[0];
                acc_next  = lsr_r;
                flag_next = with_nz(t, lsr_r);
            end
            K_LAX:
            begin
                acc_next  = d;
                x_next    = d;
                flag_next = with_nz(flag_reg, d);
            end
            K_ATX:
            begin
                acc_next  = acc_reg & d;
                x_next    = acc_reg & d;
                flag_next = with_nz(flag_reg, acc_reg & d);
            end
            K_ASL_M, K_ASL_A, K_SLO:
            begin
                t[FB_C] = sh_in[7];
                r       = asl_r;
            end
            K_LSR_M, K_LSR_A, K_SRE:
            begin
                t[FB_C] = sh_in[0];
                r       = lsr_r;
            end
            K_ROL_M, K_ROL_A, K_RLA:
            begin
                t[FB_C] = sh_in[7];
                r       = rol_r;
            end
            K_ROR_M, K_ROR_A:
            begin
                t[FB_C] = sh_in[0];
                r       = ror_r;
            end
            K_INC:
            begin
                wv_next   = inc_r;
                wr_next   = 1'b1;
                flag_next = with_nz(flag_reg, inc_r);
            end
            K_DEC:
            begin
                wv_next   = dec_r;
                wr_next   = 1'b1;
                flag_next = with_nz(flag_reg, dec_r);
            end
            K_RRA:
            begin
                wv_next   = ror_r;
                wr_next   = 1'b1;
                t[FB_V]   = adc_v;
                t[FB_C]   = sum9[8];
                acc_next  = sum9[7:0];
                flag_next = with_nz(t, sum9[7:0]);
            end
            K_ISC:
            begin
                wv_next   = inc_r;
                wr_next   = 1'b1;
                t[FB_V]   = adc_v;
                t[FB_C]   = sum9[8];
                acc_next  = sum9[7:0];
                flag_next = with_nz(t, sum9[7:0]);
            end
            K_DCP:
            begin
                wv_next   = dec_r;
                wr_next   = 1'b1;
                t[FB_C]   = ~diff9[8];
                flag_next = with_nz(t, diff9[7:0]);
            end
            K_CLC: flag_next[FB_C] = 1'b0;
            K_CLD: flag_next[FB_D] = 1'b0;
            K_CLI: flag_next[FB_I] = 1'b0;
            K_CLV: flag_next[FB_V] = 1'b0;
            K_SEC: flag_next[FB_C] = 1'b1;
            K_SED: flag_next[FB_D] = 1'b1;
            K_SEI: flag_next[FB_I] = 1'b1;
            K_DEX:
            begin
                x_next    = x_reg - 8'd1;
                flag_next = with_nz(flag_reg, x_reg - 8'd1);
            end
            K_DEY:
            begin
                y_next    = y_reg - 8'd1;
                flag_next = with_nz(flag_reg, y_reg - 8'd1);
            end
            K_INX:
            begin
                x_next    = x_reg + 8'd1;
                flag_next = with_nz(flag_reg, x_reg + 8'd1);
            end
            K_INY:
            begin
                y_next    = y_reg + 8'd1;
                flag_next = with_nz(flag_reg, y_reg + 8'd1);
            end
            K_TAX:
            begin
                x_next    = acc_reg;
                flag_next = with_nz(flag_reg, acc_reg);
            end
            K_TAY:
            begin
                y_next    = acc_reg;
                flag_next = with_nz(flag_reg, acc_reg);
            end
            K_TSX:
            begin
                x_next    = sp_reg;
                flag_next = with_nz(flag_reg, sp_reg);
            end
            K_TXA:
            begin
                acc_next  = x_reg;
                flag_next = with_nz(flag_reg, x_reg);
            end
            K_TXS: sp_next = x_reg;
            K_TYA:
            begin
                acc_next  = y_reg;
                flag_next = with_nz(flag_reg, y_reg);
            end
            K_STA:
            begin
                wv_next = acc_reg;
                wr_next = 1'b1;
            end
            K_STX:
            begin
                wv_next = x_reg;
                wr_next = 1'b1;
            end
            K_STY:
            begin
                wv_next = y_reg;
                wr_next = 1'b1;
            end
            K_SAX:
            begin
                wv_next = acc_reg & x_reg;
                wr_next = 1'b1;
            end
            K_PHA:
            begin
                wv_next = acc_reg;
                wr_next = 1'b1;
                sp_next = sp_reg - 8'd1;
            end
            K_PHP:
            begin
                wv_next = flag_reg | PUSH_STATUS_SET;
                wr_next = 1'b1;
                sp_next = sp_reg - 8'd1;
            end
            K_PLA:
            begin
                sp_next   = sp_reg + 8'd1;
                acc_next  = d;
                flag_next = with_nz(flag_reg, d);
            end
            K_PLP:
            begin
                sp_next   = sp_reg + 8'd1;
                flag_next = (d & PULL_STATUS_MASK) | PULL_STATUS_SET;
            end
            K_BCC: br_next = ~flag_reg[FB_C];
            K_BCS: br_next = flag_reg[FB_C];
            K_BVC: br_next = ~flag_reg[FB_V];
            K_BVS: br_next = flag_reg[FB_V];
            K_BNE: br_next = ~flag_reg[FB_Z];
            K_BEQ: br_next = flag_reg[FB_Z];
            K_BPL: br_next = ~flag_reg[FB_N];
            K_BMI: br_next = flag_reg[FB_N];
            default:
            begin
                flag_next = flag_reg;
            end
        endcase

        // route shift and rotate results to memory or A; SLO, SRE and RLA also combine them into A
        case (cmd_kind_reg)
            K_ASL_M, K_LSR_M, K_ROL_M, K_ROR_M:
            begin
                wv_next   = r;
                wr_next   = 1'b1;
                flag_next = with_nz(t, r);
            end
            K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A:
            begin
                acc_next  = r;
                flag_next = with_nz(t, r);
            end
            K_SLO:
            begin
                wv_next   = r;
                wr_next   = 1'b1;
                acc_next  = acc_reg | r;
                flag_next = with_nz(t, acc_reg | r);
            end
            K_SRE:
            begin
                wv_next   = r;
                wr_next   = 1'b1;
                acc_next  = acc_reg ^ r;
                flag_next = with_nz(t, acc_reg ^ r);
            end
            K_RLA:
            begin
                wv_next   = r;
                wr_next   = 1'b1;
                acc_next  = acc_reg & r;
                flag_next = with_nz(t, acc_reg & r);
            end
            default:
            begin
                r = r;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_kind_reg    <= cmd.kind;
            cmd_operand_reg <= cmd.operand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 8'h00;
            x_reg         <= 8'h00;
            y_reg         <= 8'h00;
            sp_reg        <= 8'h00;
            flag_reg      <= 8'h00;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg  <= acc_next;
                x_reg    <= x_next;
                y_reg    <= y_next;
                sp_reg   <= sp_next;
                flag_reg <= flag_next;
            end
            // hold the result until its transfer, refill on advance
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_value_reg  <= wv_next;
            res_write_reg  <= wr_next;
            res_branch_reg <= br_next;
            res_acc_reg    <= acc_next;
            res_x_reg      <= x_next;
            res_y_reg      <= y_next;
            res_sp_reg     <= sp_next;
            res_flag_reg   <= flag_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.value_out    = res_value_reg;
    assign res.mem_write    = res_write_reg;
    assign res.branch_taken = res_branch_reg;
    assign res.acc_out      = res_acc_reg;
    assign res.x_out        = res_x_reg;
    assign res.y_out        = res_y_reg;
    assign res.sp_out       = res_sp_reg;
    assign res.flags_out    = res_flag_reg;

`ifndef SYNTHESIS
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result stage not filled after advance");

    a_image_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_acc_reg == acc_reg && res_x_reg == x_reg &&
                           res_y_reg == y_reg && res_sp_reg == sp_reg &&
                           res_flag_reg == flag_reg))
        else $error("result image differs from register file");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_write_reg) |-> (res_value_reg == 8'h00))
        else $error("write byte set without write flag");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid_reg |-> cmd.ready)
        else $error("input stage empty but not ready");
`endif

endmodule
